// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the sensor compensation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/bsc_pkg.sv =====
// Package with types, constants and helper functions of the sensor compensation block.
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned RAW_W      = 20;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned DIV_STAGES = DATA_W;

   // Requested output kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_TEMP  = 2'd0,
      KIND_PRESS = 2'd1,
      KIND_HUM   = 2'd2
   } kind_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TEMP_COEFFS  = 3'd0,
      CSR_PRESS_FIRST  = 3'd1,
      CSR_PRESS_SECOND = 3'd2,
      CSR_PRESS_NINTH  = 3'd3,
      CSR_HUM_COEFFS   = 3'd4,
      CSR_HUM_SIXTH    = 3'd5
   } csr_index_type;

   // Fixed-point constants of the compensation formulas.
   localparam logic [31:0] PRESS_T_OFFSET = 32'd64000;
   localparam logic [31:0] PRESS_ADC_BASE = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE    = 32'd3125;
   localparam logic [31:0] PRESS_ONE      = 32'd32768;
   localparam logic [31:0] HUM_T_OFFSET   = 32'd76800;
   localparam logic [31:0] HUM_ROUND_A    = 32'd16384;
   localparam logic [31:0] HUM_ROUND_B    = 32'd8192;
   localparam logic [31:0] HUM_ONE        = 32'd32768;
   localparam logic [31:0] HUM_BIAS       = 32'd2097152;
   localparam logic [31:0] HUM_CLAMP      = 32'd419430400;
   localparam logic [31:0] TEMP_ROUND     = 32'd128;

   // Calibration coefficients as held by the configuration registers.
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
      logic [7:0]  h1;
      logic [15:0] h2;
      logic [7:0]  h3;
      logic [15:0] h4;
      logic [15:0] h5;
      logic [7:0]  h6;
   } coeff_type;

   // Values that ride alongside the pressure divide.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [31:0]       temp_res;
      logic [31:0]       hum_res;
      logic              dbl;
      logic              guard;
   } side_type;

   // Arithmetic right shift of a 32-bit word.
   function automatic logic [31:0] sra32(logic [31:0] v, int unsigned k);
      return $unsigned($signed(v) >>> k);
   endfunction

   // Signed division by two to the k, truncating toward zero.
   function automatic logic [31:0] sdiv_p2(logic [31:0] v, int unsigned k);
      logic [31:0] bias;
      bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
      return sra32(v + bias, k);
   endfunction

   // Sign extension of sixteen and eight bit coefficients.
   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx8(logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage
`default_nettype wire

// ===== hdl/bsc_req_if.sv =====
// Input channel interface: one raw reading item per handshake.
`timescale 1ns / 1ps
`default_nettype none
interface bsc_req_if import bsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [RAW_W-1:0]  raw_temperature;
   logic [RAW_W-1:0]  raw_value;

   modport source (output valid, kind, raw_temperature, raw_value, input ready);
   modport sink (input valid, kind, raw_temperature, raw_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsc_rsp_if.sv =====
// Result channel interface: one compensated item per handshake.
`timescale 1ns / 1ps
`default_nettype none
interface bsc_rsp_if import bsc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] compensated;
   logic                     divide_guard;

   modport source (output valid, compensated, divide_guard, input ready);
   modport sink (input valid, compensated, divide_guard, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsc_csr_if.sv =====
// Configuration write channel interface: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface bsc_csr_if import bsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsc_front.sv =====
// Twelve-stage front pipeline: fine temperature, temperature and humidity results,
// and the dividend and divisor of the pressure divide.
`timescale 1ns / 1ps
`default_nettype none
module bsc_front import bsc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [KIND_W-1:0] in_kind,
   input  wire logic [RAW_W-1:0]  in_raw_t,
   input  wire logic [RAW_W-1:0]  in_raw_v,
   input  wire coeff_type         coeff,
   output logic                   out_valid,
   output logic [31:0]            out_num,
   output logic [31:0]            out_den,
   output side_type               out_side
);

   localparam int unsigned STAGES = 12;

   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [RAW_W-1:0] raw;
      logic [31:0] tmul; logic [31:0] dd;
   } s1_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [RAW_W-1:0] raw;
      logic [31:0] ta; logic [31:0] tb;
   } s2_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [RAW_W-1:0] raw; logic [31:0] tf;
   } s3_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [RAW_W-1:0] raw; logic [31:0] tres;
      logic [31:0] pqq; logic [31:0] pm5; logic [31:0] pm2;
      logic [31:0] hdiff; logic [31:0] hm5; logic [31:0] hm6; logic [31:0] hm3;
   } s4_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [RAW_W-1:0] raw; logic [31:0] tres;
      logic [31:0] pm6; logic [31:0] pm3; logic [31:0] pm5; logic [31:0] pm2;
      logic [31:0] hv5; logic [31:0] hv2; logic [31:0] hv3;
   } s5_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [RAW_W-1:0] raw; logic [31:0] tres;
      logic [31:0] pv2; logic [31:0] pv1; logic [31:0] hv5; logic [31:0] hm;
   } s6_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [31:0] tres;
      logic [31:0] pv1c; logic [31:0] pa; logic [31:0] hv5; logic [31:0] hm2;
   } s7_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [31:0] tres;
      logic [31:0] pden; logic [31:0] pm; logic [31:0] hv5; logic [31:0] hv2;
   } s8_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [31:0] tres;
      logic [31:0] pnum; logic [31:0] pden; logic pdbl; logic pguard;
      logic [31:0] hv3;
   } s9_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [31:0] tres;
      logic [31:0] pnum; logic [31:0] pden; logic pdbl; logic pguard;
      logic [31:0] hv3; logic [31:0] hsq;
   } s10_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [31:0] tres;
      logic [31:0] pnum; logic [31:0] pden; logic pdbl; logic pguard;
      logic [31:0] hv3; logic [31:0] hmh1;
   } s11_type;
   typedef struct packed {
      logic [KIND_W-1:0] kind; logic [31:0] tres;
      logic [31:0] pnum; logic [31:0] pden; logic pdbl; logic pguard;
      logic [31:0] hres;
   } s12_type;

   s1_type  s1_in,  s1_ff;
   s2_type  s2_in,  s2_ff;
   s3_type  s3_in,  s3_ff;
   s4_type  s4_in,  s4_ff;
   s5_type  s5_in,  s5_ff;
   s6_type  s6_in,  s6_ff;
   s7_type  s7_in,  s7_ff;
   s8_type  s8_in,  s8_ff;
   s9_type  s9_in,  s9_ff;
   s10_type s10_in, s10_ff;
   s11_type s11_in, s11_ff;
   s12_type s12_in, s12_ff;
   logic [STAGES-1:0] vld_in, vld_ff;

   // Valid bits travel with the stages.
   assign vld_in = {vld_ff[STAGES-2:0], in_valid};

   // Fine temperature: the two product terms.
   always_comb begin
      logic [31:0] dsub;
      logic [31:0] d;
      dsub = {15'd0, in_raw_t[19:3]} - {15'd0, coeff.t1, 1'b0};
      d    = {16'd0, in_raw_t[19:4]} - {16'd0, coeff.t1};
      s1_in.kind = in_kind;
      s1_in.raw  = in_raw_v;
      s1_in.tmul = dsub * sx16(coeff.t2);
      s1_in.dd   = d * d;
   end

   always_comb begin
      s2_in.kind = s1_ff.kind;
      s2_in.raw  = s1_ff.raw;
      s2_in.ta   = sra32(s1_ff.tmul, 11);
      s2_in.tb   = sra32(s1_ff.dd, 12) * sx16(coeff.t3);
   end

   always_comb begin
      s3_in.kind = s2_ff.kind;
      s3_in.raw  = s2_ff.raw;
      s3_in.tf   = s2_ff.ta + sra32(s2_ff.tb, 14);
   end

   // Temperature result and the first products of pressure and humidity.
   always_comb begin
      logic [31:0] pv1;
      logic [31:0] q;
      logic [31:0] hv1;
      pv1 = sra32(s3_ff.tf, 1) - PRESS_T_OFFSET;
      q   = sra32(pv1, 2);
      hv1 = s3_ff.tf - HUM_T_OFFSET;
      s4_in.kind  = s3_ff.kind;
      s4_in.raw   = s3_ff.raw;
      s4_in.tres  = sra32((s3_ff.tf << 2) + s3_ff.tf + TEMP_ROUND, 8);
      s4_in.pqq   = q * q;
      s4_in.pm5   = pv1 * sx16(coeff.p5);
      s4_in.pm2   = sx16(coeff.p2) * pv1;
      s4_in.hdiff = {2'd0, s3_ff.raw[15:0], 14'd0} - {coeff.h4[11:0], 20'd0};
      s4_in.hm5   = sx16(coeff.h5) * hv1;
      s4_in.hm6   = hv1 * sx8(coeff.h6);
      s4_in.hm3   = hv1 * {24'd0, coeff.h3};
   end

   always_comb begin
      s5_in.kind = s4_ff.kind;
      s5_in.raw  = s4_ff.raw;
      s5_in.tres = s4_ff.tres;
      s5_in.pm6  = sra32(s4_ff.pqq, 11) * sx16(coeff.p6);
      s5_in.pm3  = sx16(coeff.p3) * sra32(s4_ff.pqq, 13);
      s5_in.pm5  = s4_ff.pm5;
      s5_in.pm2  = s4_ff.pm2;
      s5_in.hv5  = sdiv_p2(s4_ff.hdiff - s4_ff.hm5 + HUM_ROUND_A, 15);
      s5_in.hv2  = sdiv_p2(s4_ff.hm6, 10);
      s5_in.hv3  = sdiv_p2(s4_ff.hm3, 11);
   end

   always_comb begin
      s6_in.kind = s5_ff.kind;
      s6_in.raw  = s5_ff.raw;
      s6_in.tres = s5_ff.tres;
      s6_in.pv2  = sra32(s5_ff.pm6 + (s5_ff.pm5 << 1), 2) + {coeff.p4, 16'd0};
      s6_in.pv1  = sra32(sra32(s5_ff.pm3, 3) + sra32(s5_ff.pm2, 1), 18);
      s6_in.hv5  = s5_ff.hv5;
      s6_in.hm   = s5_ff.hv2 * (s5_ff.hv3 + HUM_ONE);
   end

   always_comb begin
      logic [31:0] hv4;
      hv4 = sdiv_p2(s6_ff.hm, 10) + HUM_BIAS;
      s7_in.kind = s6_ff.kind;
      s7_in.tres = s6_ff.tres;
      s7_in.pv1c = (PRESS_ONE + s6_ff.pv1) * {16'd0, coeff.p1};
      s7_in.pa   = PRESS_ADC_BASE - {12'd0, s6_ff.raw} - sra32(s6_ff.pv2, 12);
      s7_in.hv5  = s6_ff.hv5;
      s7_in.hm2  = hv4 * sx16(coeff.h2);
   end

   always_comb begin
      s8_in.kind = s7_ff.kind;
      s8_in.tres = s7_ff.tres;
      s8_in.pden = sra32(s7_ff.pv1c, 15);
      s8_in.pm   = s7_ff.pa * PRESS_SCALE;
      s8_in.hv5  = s7_ff.hv5;
      s8_in.hv2  = sdiv_p2(s7_ff.hm2 + HUM_ROUND_B, 14);
   end

   // Dividend form: a product below two to the 31 is doubled before the divide,
   // a larger one has its quotient doubled afterwards.
   always_comb begin
      s9_in.kind   = s8_ff.kind;
      s9_in.tres   = s8_ff.tres;
      s9_in.pdbl   = s8_ff.pm[31];
      s9_in.pnum   = s8_ff.pm[31] ? s8_ff.pm : {s8_ff.pm[30:0], 1'b0};
      s9_in.pden   = s8_ff.pden;
      s9_in.pguard = (s8_ff.pden == 32'd0);
      s9_in.hv3    = s8_ff.hv5 * s8_ff.hv2;
   end

   always_comb begin
      logic [31:0] s;
      s = sdiv_p2(s9_ff.hv3, 15);
      s10_in.kind   = s9_ff.kind;
      s10_in.tres   = s9_ff.tres;
      s10_in.pnum   = s9_ff.pnum;
      s10_in.pden   = s9_ff.pden;
      s10_in.pdbl   = s9_ff.pdbl;
      s10_in.pguard = s9_ff.pguard;
      s10_in.hv3    = s9_ff.hv3;
      s10_in.hsq    = s * s;
   end

   always_comb begin
      s11_in.kind   = s10_ff.kind;
      s11_in.tres   = s10_ff.tres;
      s11_in.pnum   = s10_ff.pnum;
      s11_in.pden   = s10_ff.pden;
      s11_in.pdbl   = s10_ff.pdbl;
      s11_in.pguard = s10_ff.pguard;
      s11_in.hv3    = s10_ff.hv3;
      s11_in.hmh1   = sdiv_p2(s10_ff.hsq, 7) * {24'd0, coeff.h1};
   end

   // Humidity clamp and final scaling.
   always_comb begin
      logic [31:0] hv5;
      hv5 = s11_ff.hv3 - sdiv_p2(s11_ff.hmh1, 4);
      if (hv5[31]) begin
         hv5 = 32'd0;
      end else if (hv5 > HUM_CLAMP) begin
         hv5 = HUM_CLAMP;
      end
      s12_in.kind   = s11_ff.kind;
      s12_in.tres   = s11_ff.tres;
      s12_in.pnum   = s11_ff.pnum;
      s12_in.pden   = s11_ff.pden;
      s12_in.pdbl   = s11_ff.pdbl;
      s12_in.pguard = s11_ff.pguard;
      s12_in.hres   = {12'd0, hv5[31:12]};
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage data.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s11_ff <= s11_in;
         s12_ff <= s12_in;
      end
   end

   assign out_valid      = vld_ff[STAGES-1];
   assign out_num        = s12_ff.pnum;
   assign out_den        = s12_ff.pden;
   assign out_side.kind     = s12_ff.kind;
   assign out_side.temp_res = s12_ff.tres;
   assign out_side.hum_res  = s12_ff.hres;
   assign out_side.dbl      = s12_ff.pdbl;
   assign out_side.guard    = s12_ff.pguard;

endmodule
`default_nettype wire

// ===== hdl/bsc_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, side data carried along.
`timescale 1ns / 1ps
`default_nettype none
module bsc_divider import bsc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        adv,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_num,
   input  wire logic [31:0] in_den,
   input  wire side_type    in_side,
   output logic             out_valid,
   output logic [31:0]      out_quo,
   output side_type         out_side
);

   logic [31:0]           rem_in  [DIV_STAGES];
   logic [31:0]           rem_ff  [DIV_STAGES];
   logic [31:0]           num_in  [DIV_STAGES];
   logic [31:0]           num_ff  [DIV_STAGES];
   logic [31:0]           den_in  [DIV_STAGES];
   logic [31:0]           den_ff  [DIV_STAGES];
   side_type              side_in [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_in, vld_ff;

   // Each stage shifts in one dividend bit and subtracts when it can.
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [31:0] rem_src;
      logic [31:0] num_src;
      logic [31:0] den_src;
      side_type    side_src;
      logic        vld_src;
      logic [32:0] trial;
      logic        ge;

      if (k == 0) begin : g_first
         assign rem_src  = 32'd0;
         assign num_src  = in_num;
         assign den_src  = in_den;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign num_src  = num_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      assign trial      = {rem_src, num_src[31]};
      assign ge         = (trial >= {1'b0, den_src});
      assign rem_in[k]  = ge ? 32'(trial - {1'b0, den_src}) : trial[31:0];
      assign num_in[k]  = {num_src[30:0], ge};
      assign den_in[k]  = den_src;
      assign side_in[k] = side_src;
      assign vld_in[k]  = vld_src;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage data.
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_quo   = num_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/barometric_sensor_compensation_top.sv =====
// An accepted item passes the front stages, the divider stages and the back stages into the output register.
// Throughput: one item per cycle while no result waits; 12 front stages, 32 divider stages, 3 back stages.
// The whole pipeline advances together and holds while a result waits to be taken.
// Reset (synchronous, active high) empties the pipeline and clears the coefficients.
// Coefficient writes are taken every cycle; write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module barometric_sensor_compensation_top import bsc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   bsc_req_if.sink   req_chan,
   bsc_rsp_if.source rsp_chan,
   bsc_csr_if.sink   csr_chan
);

   coeff_type   coeff_in, coeff_ff;
   logic        adv;
   logic        front_vld;
   logic [31:0] front_num;
   logic [31:0] front_den;
   side_type    front_side;
   logic        div_vld;
   logic [31:0] div_quo;
   side_type    div_side;

   logic        b1_vld_in, b1_vld_ff;
   logic [31:0] b1_p_in, b1_p_ff, b1_ps_in, b1_ps_ff, b1_m8_in, b1_m8_ff;
   side_type    b1_side_ff;
   logic        b2_vld_ff;
   logic [31:0] b2_p_ff, b2_m8_ff, b2_mv1_in, b2_mv1_ff;
   side_type    b2_side_ff;
   logic        rsp_vld_ff;
   logic [31:0] rsp_comp_in, rsp_comp_ff;
   logic        rsp_guard_in, rsp_guard_ff;
   logic [KIND_W-1:0] rsp_kind_ff;

   // The pipeline moves whenever the output register is free or being drained.
   assign adv            = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;

   // Coefficient register writes.
   always_comb begin
      coeff_in = coeff_ff;
      if (csr_chan.valid) begin
         case (csr_chan.addr)
            CSR_TEMP_COEFFS: begin
               coeff_in.t1 = csr_chan.wdata[15:0];
               coeff_in.t2 = csr_chan.wdata[31:16];
               coeff_in.t3 = csr_chan.wdata[47:32];
            end
            CSR_PRESS_FIRST: begin
               coeff_in.p1 = csr_chan.wdata[15:0];
               coeff_in.p2 = csr_chan.wdata[31:16];
               coeff_in.p3 = csr_chan.wdata[47:32];
               coeff_in.p4 = csr_chan.wdata[63:48];
            end
            CSR_PRESS_SECOND: begin
               coeff_in.p5 = csr_chan.wdata[15:0];
               coeff_in.p6 = csr_chan.wdata[31:16];
               coeff_in.p7 = csr_chan.wdata[47:32];
               coeff_in.p8 = csr_chan.wdata[63:48];
            end
            CSR_PRESS_NINTH: begin
               coeff_in.p9 = csr_chan.wdata[15:0];
            end
            CSR_HUM_COEFFS: begin
               coeff_in.h1 = csr_chan.wdata[7:0];
               coeff_in.h2 = csr_chan.wdata[23:8];
               coeff_in.h3 = csr_chan.wdata[31:24];
               coeff_in.h4 = csr_chan.wdata[47:32];
               coeff_in.h5 = csr_chan.wdata[63:48];
            end
            CSR_HUM_SIXTH: begin
               coeff_in.h6 = csr_chan.wdata[7:0];
            end
            default: begin
               coeff_in = coeff_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else begin
         coeff_ff <= coeff_in;
      end
   end

   bsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_chan.valid),
      .in_kind  (req_chan.kind),
      .in_raw_t (req_chan.raw_temperature),
      .in_raw_v (req_chan.raw_value),
      .coeff    (coeff_ff),
      .out_valid(front_vld),
      .out_num  (front_num),
      .out_den  (front_den),
      .out_side (front_side)
   );

   bsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (front_vld),
      .in_num   (front_num),
      .in_den   (front_den),
      .in_side  (front_side),
      .out_valid(div_vld),
      .out_quo  (div_quo),
      .out_side (div_side)
   );

   // Back stage one: undo the dividend form and square the pressure.
   always_comb begin
      logic [31:0] p3;
      b1_vld_in = div_vld;
      b1_p_in   = div_side.dbl ? {div_quo[30:0], 1'b0} : div_quo;
      p3        = {3'd0, b1_p_in[31:3]};
      b1_ps_in  = p3 * p3;
      b1_m8_in  = {2'd0, b1_p_in[31:2]} * sx16(coeff_ff.p8);
   end

   // Back stage two: ninth coefficient product.
   assign b2_mv1_in = sx16(coeff_ff.p9) * {13'd0, b1_ps_ff[31:13]};

   // Result selection into the output register.
   always_comb begin
      logic [31:0] pres;
      pres = b2_p_ff + sra32(sra32(b2_mv1_ff, 12) + sra32(b2_m8_ff, 13)
                             + sx16(coeff_ff.p7), 4);
      rsp_guard_in = 1'b0;
      case (b2_side_ff.kind)
         KIND_TEMP: begin
            rsp_comp_in = b2_side_ff.temp_res;
         end
         KIND_PRESS: begin
            rsp_guard_in = b2_side_ff.guard;
            rsp_comp_in  = b2_side_ff.guard ? 32'd0 : pres;
         end
         KIND_HUM: begin
            rsp_comp_in = b2_side_ff.hum_res;
         end
         default: begin
            rsp_comp_in = 32'd0;
         end
      endcase
   end

   // Control state of the back stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         b1_vld_ff  <= b1_vld_in;
         b2_vld_ff  <= b1_vld_ff;
         rsp_vld_ff <= b2_vld_ff;
      end
   end

   // Data of the back stages.
   always_ff @(posedge clock) begin
      if (adv) begin
         b1_p_ff      <= b1_p_in;
         b1_ps_ff     <= b1_ps_in;
         b1_m8_ff     <= b1_m8_in;
         b1_side_ff   <= div_side;
         b2_p_ff      <= b1_p_ff;
         b2_m8_ff     <= b1_m8_ff;
         b2_mv1_ff    <= b2_mv1_in;
         b2_side_ff   <= b1_side_ff;
         rsp_comp_ff  <= rsp_comp_in;
         rsp_guard_ff <= rsp_guard_in;
         rsp_kind_ff  <= b2_side_ff.kind;
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.compensated  = $signed(rsp_comp_ff);
   assign rsp_chan.divide_guard = rsp_guard_ff;

   // A guarded pressure item always reports zero.
   `ASSERT_IMPLY(a_guard_zero, clock, reset, rsp_vld_ff && rsp_guard_ff,
      rsp_comp_ff == 32'd0 && rsp_kind_ff == KIND_PRESS)
   // Humidity results stay inside the clamped range.
   `ASSERT_IMPLY(a_hum_range, clock, reset, rsp_vld_ff && rsp_kind_ff == KIND_HUM,
      !rsp_comp_ff[31] && rsp_comp_ff <= 32'd102400)
   // A stalled divider output stays in place.
   `ASSERT_NEXT(a_div_hold, clock, reset, !adv && div_vld, div_vld)

endmodule
`default_nettype wire
